// ===== rtl/core/kvt_pkg.sv =====
package kvt_pkg;

    localparam int DEPTH      = 32;
    localparam int KEY_BITS   = 16;
    localparam int VALUE_BITS = 32;

    localparam int KIND_W   = 3;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 6;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int FILL_W   = $clog2(DEPTH + 1);
    localparam int CNT_MAX  = (1 << CNT_W) - 1;

    localparam int S_FIELDS_W = KIND_W + KEY_BITS + VALUE_BITS;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = STATUS_W + VALUE_BITS + CNT_W + CNT_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ERASE  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 3'd3;
    localparam logic [KIND_W-1:0] KIND_COUNT  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DUP       = 2'd3;

    typedef struct packed {
        logic load;
        logic scan;
        logic rd_last;
        logic wr_move;
        logic finish;
    } kvt_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic erase_move;
        logic out_free;
    } kvt_stat_t;

    function automatic logic [CNT_W-1:0] sat_cnt(input logic [FILL_W-1:0] n);
        logic [FILL_W+CNT_W-1:0] w;
        w = (FILL_W + CNT_W)'(n);
        if (w > (FILL_W + CNT_W)'(CNT_MAX))
            return CNT_W'(CNT_MAX);
        else
            return w[CNT_W-1:0];
    endfunction

endpackage

// ===== rtl/core/kvt_ram.sv =====
module kvt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/kvt_ctrl.sv =====
module kvt_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  kvt_pkg::kvt_stat_t stat,
    output kvt_pkg::kvt_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SCAN    = 3'd1;
    localparam logic [2:0] S_RD_LAST = 3'd2;
    localparam logic [2:0] S_MOVE    = 3'd3;
    localparam logic [2:0] S_FINISH  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.scan_done) begin
                    state_next = stat.erase_move ? S_RD_LAST : S_FINISH;
                end
            end
            S_RD_LAST: begin
                cmd.rd_last = 1'b1;
                state_next  = S_MOVE;
            end
            S_MOVE: begin
                cmd.wr_move = 1'b1;
                state_next  = S_FINISH;
            end
            S_FINISH: begin
                if (stat.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/kvt_dp.sv =====
module kvt_dp (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  kvt_pkg::kvt_cmd_t               cmd,
    output kvt_pkg::kvt_stat_t              stat,
    input  logic [kvt_pkg::KIND_W-1:0]      in_kind,
    input  logic [kvt_pkg::KEY_BITS-1:0]    in_key,
    input  logic [kvt_pkg::VALUE_BITS-1:0]  in_value,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    output logic [kvt_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int AW = kvt_pkg::ADDR_W;
    localparam int FW = kvt_pkg::FILL_W;
    localparam int KW = kvt_pkg::KEY_BITS;
    localparam int VW = kvt_pkg::VALUE_BITS;

    // request fields
    logic [kvt_pkg::KIND_W-1:0] kind_reg, kind_next;
    logic [KW-1:0]              key_reg, key_next;
    logic [VW-1:0]              val_reg, val_next;

    // scan state
    logic [FW-1:0] fill_reg, fill_next;
    logic [FW-1:0] issue_reg, issue_next;
    logic          cmp_valid_reg, cmp_valid_next;
    logic [AW-1:0] cmp_idx_reg, cmp_idx_next;
    logic          hit_reg, hit_next;
    logic [AW-1:0] slot_reg, slot_next;
    logic [VW-1:0] found_reg, found_next;
    logic [FW-1:0] match_reg, match_next;

    // result register
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [kvt_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [FW-1:0] fill_m1;
    logic          issue_more;
    logic          key_hit;
    logic          val_hit;
    logic [AW-1:0] rd_addr;
    logic [KW-1:0] rd_key;
    logic [VW-1:0] rd_val;
    logic          wr_en;
    logic          wr_insert;
    logic [AW-1:0] wr_addr;
    logic [KW-1:0] wr_key;
    logic [VW-1:0] wr_val;

    logic [kvt_pkg::STATUS_W-1:0] res_status;
    logic [VW-1:0]                res_found;
    logic [FW-1:0]                res_match;
    logic [FW-1:0]                res_fill;

    assign fill_m1    = fill_reg - FW'(1);
    assign issue_more = issue_reg < fill_reg;
    assign key_hit    = cmp_valid_reg && (rd_key == key_reg);
    assign val_hit    = cmp_valid_reg && (rd_val == val_reg);

    assign stat.scan_done  = !issue_more && !cmp_valid_reg;
    assign stat.erase_move = (kind_reg == kvt_pkg::KIND_ERASE) && hit_reg
                             && (FW'(slot_reg) != fill_m1);
    assign stat.out_free   = !m_tvalid_reg || m_tready;

    // erase fills the hole with the last entry, so only one entry moves
    assign rd_addr = cmd.rd_last ? fill_m1[AW-1:0] : issue_reg[AW-1:0];

    assign wr_insert = cmd.finish && (kind_reg == kvt_pkg::KIND_INSERT) && !hit_reg
                       && (fill_reg < FW'(kvt_pkg::DEPTH));
    assign wr_en   = cmd.wr_move || wr_insert;
    assign wr_addr = cmd.wr_move ? slot_reg : fill_reg[AW-1:0];
    assign wr_key  = cmd.wr_move ? rd_key : key_reg;
    assign wr_val  = cmd.wr_move ? rd_val : val_reg;

    kvt_ram #(
        .WIDTH (KW),
        .DEPTH (kvt_pkg::DEPTH)
    ) u_key_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_key),
        .rd_addr (rd_addr),
        .rd_data (rd_key)
    );

    kvt_ram #(
        .WIDTH (VW),
        .DEPTH (kvt_pkg::DEPTH)
    ) u_val_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_val),
        .rd_addr (rd_addr),
        .rd_data (rd_val)
    );

    always_comb begin
        res_status = kvt_pkg::ST_OK;
        res_found  = '0;
        res_match  = '0;
        res_fill   = fill_reg;
        case (kind_reg)
            kvt_pkg::KIND_CLEAR: begin
                res_fill = '0;
            end
            kvt_pkg::KIND_INSERT: begin
                if (hit_reg) begin
                    res_status = kvt_pkg::ST_DUP;
                end else if (fill_reg >= FW'(kvt_pkg::DEPTH)) begin
                    res_status = kvt_pkg::ST_FULL;
                end else begin
                    res_fill = fill_reg + FW'(1);
                end
            end
            kvt_pkg::KIND_ERASE: begin
                if (!hit_reg) begin
                    res_status = kvt_pkg::ST_NOT_FOUND;
                end else begin
                    res_fill = fill_m1;
                end
            end
            kvt_pkg::KIND_LOOKUP: begin
                if (!hit_reg) begin
                    res_status = kvt_pkg::ST_NOT_FOUND;
                end else begin
                    res_found = found_reg;
                end
            end
            kvt_pkg::KIND_COUNT: begin
                res_match = match_reg;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        kind_next      = kind_reg;
        key_next       = key_reg;
        val_next       = val_reg;
        fill_next      = fill_reg;
        issue_next     = issue_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        hit_next       = hit_reg;
        slot_next      = slot_reg;
        found_next     = found_reg;
        match_next     = match_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        if (cmd.load) begin
            kind_next  = in_kind;
            key_next   = in_key;
            val_next   = in_value;
            issue_next = '0;
            hit_next   = 1'b0;
            match_next = '0;
        end

        if (cmd.scan) begin
            if (issue_more) begin
                issue_next     = issue_reg + FW'(1);
                cmp_valid_next = 1'b1;
                cmp_idx_next   = issue_reg[AW-1:0];
            end
            // read data arrives in the cycle after its address is issued
            if (key_hit) begin
                hit_next   = 1'b1;
                slot_next  = cmp_idx_reg;
                found_next = rd_val;
            end
            if (val_hit) begin
                match_next = match_reg + FW'(1);
            end
        end

        if (cmd.finish) begin
            fill_next     = res_fill;
            m_tvalid_next = 1'b1;
            m_tdata_next  = kvt_pkg::M_TDATA_W'({kvt_pkg::sat_cnt(res_fill),
                                                 kvt_pkg::sat_cnt(res_match),
                                                 res_found, res_status});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg      <= '0;
            issue_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            match_reg     <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            fill_reg      <= fill_next;
            issue_reg     <= issue_next;
            cmp_valid_reg <= cmp_valid_next;
            hit_reg       <= hit_next;
            match_reg     <= match_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        key_reg     <= key_next;
        val_reg     <= val_next;
        cmp_idx_reg <= cmp_idx_next;
        slot_reg    <= slot_next;
        found_reg   <= found_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FW'(kvt_pkg::DEPTH))
        else $error("fill level above table depth");

    a_no_write_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        !(wr_en && cmd.scan))
        else $error("table written while a scan is running");

    a_move_needs_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_move |-> (hit_reg && (kind_reg == kvt_pkg::KIND_ERASE)))
        else $error("entry moved without an erase hit");

    a_finish_shows_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> m_tvalid_reg)
        else $error("finished request produced no result");

endmodule

// ===== rtl/core/keyed_value_table.sv =====
// keyed value table: up to DEPTH unique keys, each with a value, kept in two
// single-port-write RAMs (keys and values) with registered read.
// the slave channel carries one request per beat: clear, insert, erase,
// lookup or count. the master channel returns one result per request with
// status, found value, match count and the entry count after the request.
// every request scans the N stored entries one per cycle; an erase that hits
// a slot other than the last one reads the last entry after the scan and moves
// it into the freed slot, and the result is written once the output is free.
// one request is in work at a time: a new request is not taken until the last
// one has finished, and s_tready is high only while the controller is idle.
// a finished result waits in an output register: while the receiver holds
// m_tready low the next request is still accepted and scanned, and it
// finishes once the waiting result has been taken.
// reset (aresetn low, synchronous) empties the table and drops any waiting
// result; RAM contents are not cleared and need no clearing pass.
module keyed_value_table (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [kvt_pkg::S_TDATA_W-1:0] s_tdata,  // kind[2:0], key[18:3], value[50:19]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [kvt_pkg::M_TDATA_W-1:0] m_tdata   // status[1:0], found_value[33:2],
                                                    // match_count[39:34], entry_count[45:40]
);

    localparam int KEY_LO = kvt_pkg::KIND_W;
    localparam int VAL_LO = kvt_pkg::KIND_W + kvt_pkg::KEY_BITS;

    kvt_pkg::kvt_cmd_t  cmd;
    kvt_pkg::kvt_stat_t stat;

    kvt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    kvt_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .in_kind  (s_tdata[kvt_pkg::KIND_W-1:0]),
        .in_key   (s_tdata[KEY_LO +: kvt_pkg::KEY_BITS]),
        .in_value (s_tdata[VAL_LO +: kvt_pkg::VALUE_BITS]),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule
